@@ rtl/rog_pkg.sv @@
// Shared constants and the attenuation table for the ramped object gain stage.
package rog_pkg;

    // Gain words are unsigned, 32 bits wide.
    localparam int GAIN_BITS = 32;

    // The dB-to-gain table works in Q4.28.
    localparam int TABLE_FRAC_BITS = 28;

    // Target gain range, in 1/64 dB.
    localparam int DB_MAX  = 1536;
    localparam int DB_SPAN = 7680;

    // 10^1.2 in Q4.28, the gain at +24 dB.
    localparam logic [GAIN_BITS-1:0] START_Q28 = 32'd4254415268;

    // One table entry per bit of the attenuation code.
    localparam int ATTEN_STEPS = 13;
    localparam logic [3:0] ATTEN_LAST = 4'(ATTEN_STEPS - 1);

    // About 10^(-2^i/1280) in Q0.32; entry 12 holds about 10^(-4.2) instead.
    function automatic logic [GAIN_BITS-1:0] atten_k(input logic [3:0] idx);
        logic [GAIN_BITS-1:0] k;
        unique case (idx)
            4'd0:    k = 32'd4287248048;
            4'd1:    k = 32'd4279542673;
            4'd2:    k = 32'd4264173445;
            4'd3:    k = 32'd4233600377;
            4'd4:    k = 32'd4173110275;
            4'd5:    k = 32'd4054710587;
            4'd6:    k = 32'd3827893634;
            4'd7:    k = 32'd3411614590;
            4'd8:    k = 32'd2709939993;
            4'd9:    k = 32'd1709857278;
            4'd10:   k = 32'd680706443;
            4'd11:   k = 32'd107884701;
            4'd12:   k = 32'd270994;
            default: k = 32'd0;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/ramped_object_gain.sv @@
// Per-object gain stage with a linear gain ramp, built around one shared multiplier.
//
// Each input word is either a gain update (tuser = 1) or an audio sample (tuser = 0).
// An update converts its target gain from 1/64 dB to a linear
// Q(32-GAIN_FRAC_BITS).GAIN_FRAC_BITS gain, or uses zero when the object is inactive.
// It then applies the gain at once (ramp length zero or negative) or works out the
// per-sample step for a linear ramp. The dB conversion walks the 13 bits of the
// attenuation code; each bit takes a multiply state, and a set bit a rounding state too.
// The step comes from a restoring divider that retires one quotient bit per cycle,
// 32 bits in all. A sample advances the ramp by one step, passes through the same
// multiplier, and is rounded and saturated to SAMPLE_BITS. It waits in the output
// state only while the previous result is still held in the output register.
// The block takes one word at a time. s_axis_tready is high only while the
// sequencer is idle. The output register decouples the result side, so a new word
// is taken while a finished sample still waits for m_axis_tready.
module ramped_object_gain #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 28,
    parameter int RAMP_BITS      = 15
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // input stream
    input  logic                                         s_axis_tvalid,
    output logic                                         s_axis_tready,
    // tdata: sample_value, active, gain_db[13:0], ramp_len[15:0], zero pad
    input  logic [((SAMPLE_BITS + 31 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: operation (0 = sample, 1 = gain update)
    input  logic                                         s_axis_tuser,
    // result stream
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // tdata: sample_out, zero pad
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]     m_axis_tdata
);

    localparam int GB    = rog_pkg::GAIN_BITS;
    localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

    // Bit positions of the input fields inside s_axis_tdata.
    localparam int ACT_POS  = SAMPLE_BITS;
    localparam int DB_LO    = SAMPLE_BITS + 1;
    localparam int RAMP_LO  = SAMPLE_BITS + 15;

    // Conversion from the Q4.28 table result to the gain format.
    localparam int SH_UP = (GAIN_FRAC_BITS >= rog_pkg::TABLE_FRAC_BITS) ?
                           GAIN_FRAC_BITS - rog_pkg::TABLE_FRAC_BITS : 0;
    localparam int SH_DN = (GAIN_FRAC_BITS < rog_pkg::TABLE_FRAC_BITS) ?
                           rog_pkg::TABLE_FRAC_BITS - GAIN_FRAC_BITS : 1;

    localparam logic [GB-1:0] UNITY     = GB'(1) << GAIN_FRAC_BITS;
    localparam logic [GB-1:0] GAIN_MAX  = {GB{1'b1}};
    localparam logic [GB-1:0] UP_LIMIT  = GAIN_MAX >> SH_UP;
    localparam logic [31:0]   RAMP_MAX  = 32'((64'd1 << RAMP_BITS) - 64'd1);

    // Rounding and saturation of the scaled sample.
    localparam logic signed [64:0] RND_HALF = 65'sd1 <<< (GAIN_FRAC_BITS - 1);
    localparam logic signed [64:0] SAT_HI   = (65'sd1 <<< (SAMPLE_BITS - 1)) - 65'sd1;
    localparam logic signed [64:0] SAT_LO   = -SAT_HI - 65'sd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DB_MUL,
        ST_DB_RND,
        ST_DB_FIN,
        ST_SET,
        ST_DIV,
        ST_STEP,
        ST_RAMP,
        ST_SMUL,
        ST_SOUT
    } state_t;

    state_t                        state_reg;

    // Model state
    logic [GB-1:0]                 current_reg;
    logic [GB-1:0]                 target_reg;
    logic signed [GB:0]            step_reg;
    logic [RAMP_BITS-1:0]          ramp_reg;

    // Working registers
    logic [12:0]                   atten_reg;
    logic [3:0]                    idx_reg;
    logic [GB-1:0]                 v_reg;
    logic [RAMP_BITS-1:0]          len_reg;
    logic [GB-1:0]                 dvd_reg;
    logic [RAMP_BITS-1:0]          rem_reg;
    logic [4:0]                    cnt_reg;
    logic                          neg_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [64:0]            mul_reg;

    // Output register
    logic                          m_valid_reg;
    logic [SAMPLE_BITS-1:0]        out_reg;

    // Input field decode
    logic signed [13:0]            in_db;
    logic signed [15:0]            in_ramp;
    logic signed [14:0]            atten_full;
    logic [12:0]                   atten_clamped;
    logic [31:0]                   ramp_ext;
    logic [RAMP_BITS-1:0]          len_clamped;

    // Shared multiplier
    logic signed [GB:0]            mul_a;
    logic signed [GB:0]            mul_b;
    logic signed [2*GB+1:0]        mul_full;

    logic [GB-1:0]                 v_rounded;
    logic [GB-1:0]                 gain_conv;
    logic [GB:0]                   conv_sum;
    logic signed [GB:0]            gain_diff;
    logic [GB-1:0]                 diff_mag;
    logic [RAMP_BITS:0]            div_shift;
    logic [RAMP_BITS:0]            div_sub;
    logic                          div_ge;
    logic signed [GB+1:0]          gain_sum;
    logic [GB-1:0]                 gain_ramped;
    logic signed [64:0]            prod_rnd;
    logic signed [64:0]            prod_shr;
    logic [SAMPLE_BITS-1:0]        sample_sat;

    assign in_db   = s_axis_tdata[DB_LO + 13:DB_LO];
    assign in_ramp = s_axis_tdata[RAMP_LO + 15:RAMP_LO];

    // Clamp gain_db to -96..+24 dB and turn it into an attenuation code below +24 dB.
    always_comb begin
        atten_full = 15'(rog_pkg::DB_MAX) - 15'(in_db);
        if (atten_full < 15'sd0) begin
            atten_clamped = 13'd0;
        end else if (atten_full > 15'(rog_pkg::DB_SPAN)) begin
            atten_clamped = 13'(rog_pkg::DB_SPAN);
        end else begin
            atten_clamped = atten_full[12:0];
        end
    end

    // Clamp the ramp length to 0..2^RAMP_BITS-1.
    always_comb begin
        ramp_ext = 32'(in_ramp[14:0]);
        if (in_ramp[15]) begin
            len_clamped = '0;
        end else if (ramp_ext > RAMP_MAX) begin
            len_clamped = RAMP_BITS'(RAMP_MAX);
        end else begin
            len_clamped = RAMP_BITS'(ramp_ext);
        end
    end

    // Shared multiplier: sample times gain in the sample multiply state, table step otherwise.
    always_comb begin
        if (state_reg == ST_SMUL) begin
            mul_a = (GB + 1)'(sample_reg);
            mul_b = $signed({1'b0, current_reg});
        end else begin
            mul_a = $signed({1'b0, v_reg});
            mul_b = $signed({1'b0, rog_pkg::atten_k(idx_reg)});
        end
        mul_full = mul_a * mul_b;
    end

    // Drop the 32 fraction bits of the table product, ties rounded up.
    assign v_rounded = mul_reg[63:32] + GB'(mul_reg[31]);

    // Move the Q4.28 result to the gain format.
    always_comb begin
        conv_sum = {1'b0, v_reg} + ((GB + 1)'(1) << (SH_DN - 1));
        if (GAIN_FRAC_BITS >= rog_pkg::TABLE_FRAC_BITS) begin
            gain_conv = (v_reg > UP_LIMIT) ? GAIN_MAX : GB'(v_reg << SH_UP);
        end else begin
            gain_conv = GB'(conv_sum >> SH_DN);
        end
    end

    // Distance to the target, split into sign and magnitude for the divider.
    assign gain_diff = $signed({1'b0, target_reg}) - $signed({1'b0, current_reg});
    assign diff_mag  = gain_diff[GB] ? GB'(-gain_diff) : GB'(gain_diff);

    // One restoring division step.
    assign div_shift = {rem_reg, dvd_reg[GB-1]};
    assign div_ge    = div_shift >= {1'b0, len_reg};
    assign div_sub   = div_shift - {1'b0, len_reg};

    // Ramp advance, clamped to the unsigned gain range.
    always_comb begin
        gain_sum = $signed({2'b00, current_reg}) + (GB + 2)'(step_reg);
        if (gain_sum[GB+1]) begin
            gain_ramped = '0;
        end else if (gain_sum[GB]) begin
            gain_ramped = GAIN_MAX;
        end else begin
            gain_ramped = gain_sum[GB-1:0];
        end
    end

    // Round half up, floor shift, saturate to the sample width.
    always_comb begin
        prod_rnd = mul_reg + RND_HALF;
        prod_shr = prod_rnd >>> GAIN_FRAC_BITS;
        if (prod_shr > SAT_HI) begin
            sample_sat = SAMPLE_BITS'(SAT_HI);
        end else if (prod_shr < SAT_LO) begin
            sample_sat = SAMPLE_BITS'(SAT_LO);
        end else begin
            sample_sat = SAMPLE_BITS'(prod_shr);
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            current_reg <= UNITY;
            target_reg  <= UNITY;
            step_reg    <= '0;
            ramp_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop the held result once it is taken; the output state reloads it itself.
            if (m_valid_reg && m_axis_tready && (state_reg != ST_SOUT)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
                        atten_reg  <= atten_clamped;
                        len_reg    <= len_clamped;
                        v_reg      <= rog_pkg::START_Q28;
                        idx_reg    <= '0;
                        if (!s_axis_tuser) begin
                            state_reg <= ST_RAMP;
                        end else if (s_axis_tdata[ACT_POS]) begin
                            state_reg <= ST_DB_MUL;
                        end else begin
                            target_reg <= '0;
                            state_reg  <= ST_SET;
                        end
                    end
                end

                ST_DB_MUL: begin
                    mul_reg <= mul_full[64:0];
                    if (atten_reg[idx_reg]) begin
                        state_reg <= ST_DB_RND;
                    end else if (idx_reg == rog_pkg::ATTEN_LAST) begin
                        state_reg <= ST_DB_FIN;
                    end else begin
                        idx_reg <= idx_reg + 4'd1;
                    end
                end

                ST_DB_RND: begin
                    v_reg <= v_rounded;
                    if (idx_reg == rog_pkg::ATTEN_LAST) begin
                        state_reg <= ST_DB_FIN;
                    end else begin
                        idx_reg   <= idx_reg + 4'd1;
                        state_reg <= ST_DB_MUL;
                    end
                end

                ST_DB_FIN: begin
                    target_reg <= gain_conv;
                    state_reg  <= ST_SET;
                end

                ST_SET: begin
                    ramp_reg <= len_reg;
                    if (len_reg == '0) begin
                        // Jump straight to the target.
                        current_reg <= target_reg;
                        step_reg    <= '0;
                        state_reg   <= ST_IDLE;
                    end else begin
                        neg_reg   <= gain_diff[GB];
                        dvd_reg   <= diff_mag;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end

                ST_DIV: begin
                    rem_reg <= div_ge ? div_sub[RAMP_BITS-1:0] : div_shift[RAMP_BITS-1:0];
                    dvd_reg <= {dvd_reg[GB-2:0], div_ge};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'(GB - 1)) begin
                        state_reg <= ST_STEP;
                    end
                end

                ST_STEP: begin
                    // Quotient truncated toward zero, sign restored.
                    step_reg  <= neg_reg ? ((GB + 1)'(0) - {1'b0, dvd_reg}) : {1'b0, dvd_reg};
                    state_reg <= ST_IDLE;
                end

                ST_RAMP: begin
                    if (ramp_reg != '0) begin
                        ramp_reg <= ramp_reg - RAMP_BITS'(1);
                        // Land exactly on the target at the last step.
                        current_reg <= (ramp_reg == RAMP_BITS'(1)) ? target_reg : gain_ramped;
                    end
                    state_reg <= ST_SMUL;
                end

                ST_SMUL: begin
                    mul_reg   <= mul_full[64:0];
                    state_reg <= ST_SOUT;
                end

                ST_SOUT: begin
                    // Hold until the output register is free.
                    if (!m_valid_reg || m_axis_tready) begin
                        out_reg     <= sample_sat;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/sv/ramped_object_gain_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the ramped object gain stage: predicts every scaled sample and compares it.
module ramped_object_gain_checker #(
    parameter int SAMPLE_BITS    = 24,
    parameter int GAIN_FRAC_BITS = 28,
    parameter int RAMP_BITS      = 15
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_axis_tvalid,
    input  logic                                         s_axis_tready,
    // tdata: sample_value, active, gain_db[13:0], ramp_len[15:0], zero pad
    input  logic [((SAMPLE_BITS + 31 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // tuser: operation (0 = sample, 1 = gain update)
    input  logic                                         s_axis_tuser,
    input  logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // tdata: sample_out, zero pad
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]     m_axis_tdata,
    output int                                           fail_count,
    output int                                           pending
);

    localparam int     DB_FLOOR   = -6144;
    localparam int     DB_CEIL    = 1536;
    localparam longint RAMP_MAX   = (64'sd1 <<< RAMP_BITS) - 1;
    localparam longint GAIN_MAX   = 64'sh0000_0000_FFFF_FFFF;
    localparam longint SAT_HI     = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO     = -SAT_HI - 1;
    localparam logic [31:0] UNITY = 32'd1 << GAIN_FRAC_BITS;

    // model state
    logic [31:0] cur_gain;
    logic [31:0] tgt_gain;
    longint      step_per_sample;
    longint      ramp_left;

    logic [SAMPLE_BITS-1:0] scaled_q[$];

    // Q0.32 attenuation per bit of the dB code
    function automatic logic [63:0] atten_coef(input int idx);
        case (idx)
            0:       return 64'd4287248048;
            1:       return 64'd4279542673;
            2:       return 64'd4264173445;
            3:       return 64'd4233600377;
            4:       return 64'd4173110275;
            5:       return 64'd4054710587;
            6:       return 64'd3827893634;
            7:       return 64'd3411614590;
            8:       return 64'd2709939993;
            9:       return 64'd1709857278;
            10:      return 64'd680706443;
            11:      return 64'd107884701;
            default: return 64'd270994;
        endcase
    endfunction

    function automatic logic [31:0] db_to_linear(input logic signed [13:0] db);
        longint      x;
        logic [12:0] code;
        logic [63:0] v;
        int          sh;
        x = db;
        if (x < DB_FLOOR) x = DB_FLOOR;
        if (x > DB_CEIL) x = DB_CEIL;
        code = 13'(DB_CEIL - x);
        v = 64'd4254415268;
        for (int i = 0; i < 13; i++) begin
            if (code[i]) v = (v * atten_coef(i) + 64'h8000_0000) >> 32;
        end
        if (GAIN_FRAC_BITS >= 28) begin
            sh = GAIN_FRAC_BITS - 28;
            if (v > (64'hFFFF_FFFF >> sh)) return 32'hFFFF_FFFF;
            return 32'(v << sh);
        end
        sh = 28 - GAIN_FRAC_BITS;
        return 32'((v + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function automatic void apply_update(input logic active, input logic signed [13:0] db,
                                         input logic signed [15:0] ramp);
        longint len;
        longint t;
        longint c;
        tgt_gain = active ? db_to_linear(db) : 32'd0;
        len = ramp;
        if (len < 0) len = 0;
        if (len > RAMP_MAX) len = RAMP_MAX;
        ramp_left = len;
        if (len == 0) begin
            step_per_sample = 0;
            cur_gain = tgt_gain;
        end else begin
            t = {32'd0, tgt_gain};
            c = {32'd0, cur_gain};
            step_per_sample = (t - c) / len;
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] advance_and_scale(
            input logic signed [SAMPLE_BITS-1:0] s);
        longint g;
        longint sv;
        longint p;
        if (ramp_left > 0) begin
            ramp_left--;
            if (ramp_left == 0) begin
                cur_gain = tgt_gain;
            end else begin
                g = {32'd0, cur_gain};
                g = g + step_per_sample;
                if (g < 0) g = 0;
                if (g > GAIN_MAX) g = GAIN_MAX;
                cur_gain = g[31:0];
            end
        end
        sv = s;
        g = {32'd0, cur_gain};
        p = sv * g + (64'sd1 <<< (GAIN_FRAC_BITS - 1));
        p = p >>> GAIN_FRAC_BITS;
        if (p > SAT_HI) p = SAT_HI;
        if (p < SAT_LO) p = SAT_LO;
        return p[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge aclk) begin : watch
        logic [SAMPLE_BITS-1:0] want;
        logic [SAMPLE_BITS-1:0] got;
        if (!aresetn) begin
            cur_gain = UNITY;
            tgt_gain = UNITY;
            step_per_sample = 0;
            ramp_left = 0;
            scaled_q.delete();
        end else begin
            // retire results before taking the new word
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[SAMPLE_BITS-1:0];
                if (scaled_q.size() == 0) begin
                    $display("%0t: unexpected sample_out, expected none, got %0d (0x%h)",
                             $time, $signed(got), got);
                    fail_count++;
                end else begin
                    want = scaled_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: sample_out mismatch, expected %0d (0x%h), got %0d (0x%h)",
                                 $time, $signed(want), want, $signed(got), got);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser)
                    apply_update(s_axis_tdata[SAMPLE_BITS],
                                 s_axis_tdata[SAMPLE_BITS+14:SAMPLE_BITS+1],
                                 s_axis_tdata[SAMPLE_BITS+30:SAMPLE_BITS+15]);
                else
                    scaled_q.push_back(advance_and_scale(s_axis_tdata[SAMPLE_BITS-1:0]));
            end
        end
        pending = scaled_q.size();
    end

endmodule

@@ tb/sv/tb_ramped_object_gain.sv @@
`timescale 1ns / 1ps
// Stimulus, idling control and final verdict for the ramped object gain stage.
module tb_ramped_object_gain;

    localparam int SAMPLE_BITS    = 24;
    localparam int GAIN_FRAC_BITS = 28;
    localparam int RAMP_BITS      = 15;
    localparam int IN_W           = ((SAMPLE_BITS + 31 + 7) / 8) * 8;
    localparam int OUT_W          = ((SAMPLE_BITS + 7) / 8) * 8;

    // operation codes carried on tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [23:0] PCM_MAX = 24'h7F_FFFF;
    localparam logic [23:0] PCM_MIN = 24'h80_0000;

    localparam int TAIL_CYCLES   = 100;
    localparam int WORDS_PER_PHASE = 180;

    logic             aclk          = 1'b0;
    logic             aresetn       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;
    logic             s_axis_tuser  = 1'b0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;

    // idling knobs, percent of cycles
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // long hold-off on the result side, counted down by the ready process
    int hold_cycles  = 0;

    ramped_object_gain #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
        .RAMP_BITS     (RAMP_BITS)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    ramped_object_gain_checker #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
        .RAMP_BITS     (RAMP_BITS)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Drive ready at the falling edge: hold it low during a requested hold-off,
    // otherwise stall at the current rate.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                hold_cycles--;
            end else begin
                m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offer one word, idling first at the sender rate. Enter and leave at a falling edge.
    // Keep tvalid high between back-to-back words so it is never dropped and raised
    // in the same step.
    task automatic send_word(input logic op, input logic [SAMPLE_BITS-1:0] sample,
                             input logic active, input logic [13:0] db,
                             input logic [15:0] ramp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = '0;
        s_axis_tdata[SAMPLE_BITS+30:0] = {ramp, db, active, sample};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    // Mostly full-range PCM, with a share of extremes and near-zero values.
    function automatic logic [SAMPLE_BITS-1:0] rand_pcm();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70) return SAMPLE_BITS'($urandom);
        if (pick < 85) begin
            case ($urandom_range(4))
                0:       return PCM_MAX;
                1:       return PCM_MIN;
                2:       return '0;
                3:       return '1;
                default: return SAMPLE_BITS'(1);
            endcase
        end
        return SAMPLE_BITS'($urandom_range(2000) - 1000);
    endfunction

    // Sample words carry random junk in the fields the block ignores.
    task automatic send_rand_sample();
        send_word(OP_SAMPLE, rand_pcm(), 1'($urandom), 14'($urandom), 16'($urandom));
    endtask

    // Mostly in-range dB and short ramps so that ramps run to completion;
    // the rest covers clamping, negative and very long ramps, and inactive objects.
    task automatic send_rand_update();
        logic        act;
        logic [13:0] db;
        logic [15:0] ramp;
        int          pick;
        act = ($urandom_range(99) < 85);
        if ($urandom_range(99) < 80) db = 14'($urandom_range(7680) - 6144);
        else db = 14'($urandom);
        pick = $urandom_range(99);
        if (pick < 40) ramp = 16'($urandom_range(1, 8));
        else if (pick < 70) ramp = 16'($urandom_range(9, 64));
        else if (pick < 80) ramp = 16'(-$urandom_range(1, 32768));
        else if (pick < 90) ramp = '0;
        else ramp = 16'($urandom);
        send_word(OP_UPDATE, SAMPLE_BITS'($urandom), act, db, ramp);
    endtask

    // An update followed by a run of samples; sometimes updates come back to back.
    task automatic run_phase(input int goal);
        int sent;
        int run_len;
        sent = 0;
        while (sent < goal) begin
            send_rand_update();
            sent++;
            run_len = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 20);
            repeat (run_len) begin
                send_rand_sample();
                sent++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge aclk);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // unity gain after reset: extremes pass straight through
        send_word(OP_SAMPLE, PCM_MAX, 1'b1, 14'h3FFF, 16'hFFFF);
        send_word(OP_SAMPLE, PCM_MIN, 1'b0, 14'h0000, 16'h0000);
        send_word(OP_SAMPLE, '0, 1'b1, 14'h2000, 16'h8000);
        send_word(OP_SAMPLE, '1, 1'b0, 14'h1FFF, 16'h7FFF);
        // top of the dB range at once; junk in sample_value must be ignored
        send_word(OP_UPDATE, 24'hAB_CDEF, 1'b1, 14'd1536, 16'd0);
        send_word(OP_SAMPLE, PCM_MAX, 1'b0, 14'd0, 16'd5);
        send_word(OP_SAMPLE, PCM_MIN, 1'b0, 14'd0, 16'd5);
        send_word(OP_SAMPLE, 24'd1000, 1'b0, 14'd0, 16'd5);
        // bottom of the dB range
        send_word(OP_UPDATE, 24'h55_5555, 1'b1, 14'(-6144), 16'd0);
        send_word(OP_SAMPLE, PCM_MAX, 1'b1, 14'd0, 16'd0);
        send_word(OP_SAMPLE, PCM_MIN, 1'b1, 14'd0, 16'd0);
        // dB above range clamps; negative ramp applies at once
        send_word(OP_UPDATE, '0, 1'b1, 14'h1FFF, 16'hFFFF);
        send_word(OP_SAMPLE, 24'd12345, 1'b1, 14'd0, 16'd0);
        // dB below range clamps; most negative ramp
        send_word(OP_UPDATE, '1, 1'b1, 14'h2000, 16'h8000);
        send_word(OP_SAMPLE, PCM_MIN, 1'b1, 14'd0, 16'd0);
        // ramp back to 0 dB over four samples, landing on the target
        send_word(OP_UPDATE, '0, 1'b1, 14'd0, 16'd4);
        repeat (4) send_word(OP_SAMPLE, PCM_MAX, 1'b0, 14'd0, 16'd0);
        // inactive object ramps to silence
        send_word(OP_UPDATE, '0, 1'b0, 14'd700, 16'd3);
        repeat (3) send_word(OP_SAMPLE, PCM_MIN, 1'b1, 14'd0, 16'd0);
        // longest ramp
        send_word(OP_UPDATE, '0, 1'b1, 14'd384, 16'h7FFF);
        send_word(OP_SAMPLE, PCM_MAX, 1'b1, 14'd0, 16'd0);

        // No idling. Hold off the result side long enough for the block to fill
        // and stall its input while words keep coming.
        @(posedge aclk);
        hold_cycles = 300;
        @(negedge aclk);
        repeat (12) send_rand_sample();
        run_phase(WORDS_PER_PHASE);

        // Sender idles; pause until every result is back before going on.
        tx_idle_pct  = 53;
        rx_stall_pct = 0;
        run_phase(WORDS_PER_PHASE);
        s_axis_tvalid = 1'b0;
        wait_drained();

        // Receiver stalls.
        tx_idle_pct  = 0;
        rx_stall_pct = 53;
        run_phase(WORDS_PER_PHASE);

        // Both sides idle.
        tx_idle_pct  = 35;
        rx_stall_pct = 35;
        run_phase(WORDS_PER_PHASE);

        // Drop valid, drain, and let the block settle before the verdict.
        s_axis_tvalid = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: the slowest legal run is well under a tenth of this.
    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
